>>> rtl/core/dts_pkg.sv
// Package with the command codes, result codes, controller states and control struct.
package dts_pkg;

    // Field widths of one input item and one result item.
    localparam int unsigned CMD_W  = 3;
    localparam int unsigned CHAN_W = 12;
    localparam int unsigned FREQ_W = 20;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned CNT_W  = 5;

    // Command codes; the remaining codes change nothing and answer as a query.
    localparam logic [CMD_W-1:0] CMD_TOGGLE_DEL  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TOGGLE_SKIP = 3'd1;
    localparam logic [CMD_W-1:0] CMD_COMPARE     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH_DEL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH_SKIP = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_ADDED   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_REMOVED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_QUERY   = 2'd3;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } dts_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } dts_ctrl_t;

endpackage

>>> rtl/core/dts_cmd_if.sv
// Handshake channel that carries one command item.
interface dts_cmd_if
    import dts_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [CHAN_W-1:0] channel;
    logic [FREQ_W-1:0] frequency;

    modport source (output valid, output cmd, output channel, output frequency, input ready);
    modport sink (input valid, input cmd, input channel, input frequency, output ready);
endinterface

>>> rtl/core/dts_res_if.sv
// Handshake channel that carries one result item.
interface dts_res_if
    import dts_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic              found;
    logic              sets_equal;
    logic [CNT_W-1:0]  delete_count;
    logic [CNT_W-1:0]  skip_count;

    modport source (output valid, output status, output found, output sets_equal,
                    output delete_count, output skip_count, input ready);
    modport sink (input valid, input status, input found, input sets_equal,
                  input delete_count, input skip_count, output ready);
endinterface

>>> rtl/core/dts_ctrl.sv
// Controller: sequences the slot scan and hands finished results to the output register.
module dts_ctrl
    import dts_pkg::*;
#(
    parameter int unsigned ENTRIES = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  logic                       out_ready,
    output dts_ctrl_t                  ctrl,
    output logic [$clog2(ENTRIES)-1:0] idx
);

    localparam int unsigned IDX_W = $clog2(ENTRIES);

    dts_state_t       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic             last_slot;

    assign last_slot = (idx_reg == IDX_W'(ENTRIES - 1));
    assign idx       = idx_reg;
    assign out_valid = out_valid_reg;

    // State, slot index and result valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        in_ready    = 1'b0;
        ctrl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.start = 1'b1;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ctrl.scan = 1'b1;
                idx_next  = idx_reg + IDX_W'(1);
                if (last_slot)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                // Wait until the output register is free or is being emptied.
                if (!out_valid_reg || out_ready)
                begin
                    ctrl.commit = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The result register fills on commit and empties when the sink takes the item.
    always_comb
    begin
        if (ctrl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // A result appears only after a commit.
    a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_COMMIT))
        else $error("result valid rose without a commit");

    // An accepted item starts a scan at the first slot.
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_SCAN && idx_reg == '0))
        else $error("scan did not start at slot zero");

    // A commit never overwrites a result that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.commit && out_valid_reg) |-> out_ready)
        else $error("result overwritten before it was taken");

endmodule

>>> rtl/core/dts_dp.sv
// Datapath: both pair tables, the per-slot compare, the counts and the result register.
module dts_dp
    import dts_pkg::*;
#(
    parameter int unsigned ENTRIES = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  dts_ctrl_t                  ctrl,
    input  logic [$clog2(ENTRIES)-1:0] idx,
    input  logic [CMD_W-1:0]           in_cmd,
    input  logic [CHAN_W-1:0]          in_channel,
    input  logic [FREQ_W-1:0]          in_frequency,
    output logic [STAT_W-1:0]          status,
    output logic                       found,
    output logic                       sets_equal,
    output logic [CNT_W-1:0]           delete_count,
    output logic [CNT_W-1:0]           skip_count
);

    localparam int unsigned IDX_W = $clog2(ENTRIES);
    localparam int unsigned TOT_W = $clog2(ENTRIES + 1);

    // Tables: valid bits are reset, pair payload is not.
    logic [ENTRIES-1:0] del_valid_reg;
    logic [ENTRIES-1:0] skip_valid_reg;
    logic [CHAN_W-1:0]  del_chan_reg  [ENTRIES];
    logic [FREQ_W-1:0]  del_freq_reg  [ENTRIES];
    logic [CHAN_W-1:0]  skip_chan_reg [ENTRIES];
    logic [FREQ_W-1:0]  skip_freq_reg [ENTRIES];
    logic [TOT_W-1:0]   del_cnt_reg, del_cnt_next;
    logic [TOT_W-1:0]   skip_cnt_reg, skip_cnt_next;

    // Latched item and scan flags.
    logic [CMD_W-1:0]   cmd_reg;
    logic [CHAN_W-1:0]  chan_reg;
    logic [FREQ_W-1:0]  freq_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic               free_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic               mismatch_reg;

    // Result register payload.
    logic [STAT_W-1:0]  status_reg, status_next;
    logic               found_reg, found_next;
    logic               equal_reg, equal_next;
    logic [TOT_W+CNT_W-1:0] del_cnt_ext;
    logic [TOT_W+CNT_W-1:0] skip_cnt_ext;

    logic               use_skip;
    logic               is_toggle;
    logic               is_search;
    logic               del_hit;
    logic               skip_hit;
    logic               sel_valid;
    logic               sel_hit;
    logic [ENTRIES-1:0] skip_match;
    logic               in_skip;
    logic               do_add;
    logic               do_remove;

    assign use_skip  = (cmd_reg == CMD_TOGGLE_SKIP) || (cmd_reg == CMD_SEARCH_SKIP);
    assign is_toggle = (cmd_reg == CMD_TOGGLE_DEL) || (cmd_reg == CMD_TOGGLE_SKIP);
    assign is_search = (cmd_reg == CMD_SEARCH_DEL) || (cmd_reg == CMD_SEARCH_SKIP);

    // Compare the slot under scan against the latched pair.
    assign del_hit   = del_valid_reg[idx] && (del_chan_reg[idx] == chan_reg)
                       && (del_freq_reg[idx] == freq_reg);
    assign skip_hit  = skip_valid_reg[idx] && (skip_chan_reg[idx] == chan_reg)
                       && (skip_freq_reg[idx] == freq_reg);
    assign sel_valid = use_skip ? skip_valid_reg[idx] : del_valid_reg[idx];
    assign sel_hit   = use_skip ? skip_hit : del_hit;

    // Search the whole skip set for the delete-set pair under scan.
    always_comb
    begin
        for (int j = 0; j < ENTRIES; j++)
        begin
            skip_match[j] = skip_valid_reg[j] && (skip_chan_reg[j] == del_chan_reg[idx])
                            && (skip_freq_reg[j] == del_freq_reg[idx]);
        end
    end
    assign in_skip = |skip_match;

    // Latch the item and collect the scan flags one slot per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            mismatch_reg <= 1'b0;
        end
        else if (ctrl.start)
        begin
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            mismatch_reg <= 1'b0;
        end
        else if (ctrl.scan)
        begin
            if (sel_hit && !hit_reg)
            begin
                hit_reg <= 1'b1;
            end
            if (!sel_valid && !free_reg)
            begin
                free_reg <= 1'b1;
            end
            if (del_valid_reg[idx] && !in_skip)
            begin
                mismatch_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            cmd_reg  <= in_cmd;
            chan_reg <= in_channel;
            freq_reg <= in_frequency;
        end
        if (ctrl.scan && sel_hit && !hit_reg)
        begin
            hit_idx_reg <= idx;
        end
        if (ctrl.scan && !sel_valid && !free_reg)
        begin
            free_idx_reg <= idx;
        end
    end

    // Decide the table update and the result at commit.
    assign do_remove = ctrl.commit && is_toggle && hit_reg;
    assign do_add    = ctrl.commit && is_toggle && !hit_reg && free_reg;

    always_comb
    begin
        del_cnt_next  = del_cnt_reg;
        skip_cnt_next = skip_cnt_reg;
        if (do_remove)
        begin
            if (use_skip)
            begin
                skip_cnt_next = skip_cnt_reg - TOT_W'(1);
            end
            else
            begin
                del_cnt_next = del_cnt_reg - TOT_W'(1);
            end
        end
        else if (do_add)
        begin
            if (use_skip)
            begin
                skip_cnt_next = skip_cnt_reg + TOT_W'(1);
            end
            else
            begin
                del_cnt_next = del_cnt_reg + TOT_W'(1);
            end
        end
    end

    always_comb
    begin
        if (!is_toggle)
        begin
            status_next = STAT_QUERY;
        end
        else if (hit_reg)
        begin
            status_next = STAT_REMOVED;
        end
        else if (free_reg)
        begin
            status_next = STAT_ADDED;
        end
        else
        begin
            status_next = STAT_FULL;
        end
        found_next = is_search && hit_reg;
        equal_next = (cmd_reg == CMD_COMPARE) && !mismatch_reg
                     && (del_cnt_reg == skip_cnt_reg);
    end

    // Valid bits and counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            del_valid_reg  <= '0;
            skip_valid_reg <= '0;
            del_cnt_reg    <= '0;
            skip_cnt_reg   <= '0;
        end
        else
        begin
            del_cnt_reg  <= del_cnt_next;
            skip_cnt_reg <= skip_cnt_next;
            if (do_remove)
            begin
                if (use_skip)
                begin
                    skip_valid_reg[hit_idx_reg] <= 1'b0;
                end
                else
                begin
                    del_valid_reg[hit_idx_reg] <= 1'b0;
                end
            end
            else if (do_add)
            begin
                if (use_skip)
                begin
                    skip_valid_reg[free_idx_reg] <= 1'b1;
                end
                else
                begin
                    del_valid_reg[free_idx_reg] <= 1'b1;
                end
            end
        end
    end

    // Pair payload of a newly added slot.
    always_ff @(posedge clk)
    begin
        if (do_add)
        begin
            if (use_skip)
            begin
                skip_chan_reg[free_idx_reg] <= chan_reg;
                skip_freq_reg[free_idx_reg] <= freq_reg;
            end
            else
            begin
                del_chan_reg[free_idx_reg] <= chan_reg;
                del_freq_reg[free_idx_reg] <= freq_reg;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
            equal_reg  <= equal_next;
        end
    end

    // Counts are reported in their low bits.
    assign del_cnt_ext  = {{CNT_W{1'b0}}, del_cnt_reg};
    assign skip_cnt_ext = {{CNT_W{1'b0}}, skip_cnt_reg};

    assign status       = status_reg;
    assign found        = found_reg;
    assign sets_equal   = equal_reg;
    assign delete_count = del_cnt_ext[CNT_W-1:0];
    assign skip_count   = skip_cnt_ext[CNT_W-1:0];

    // Each count always equals the number of valid slots in its table.
    a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(del_valid_reg) == int'(del_cnt_reg))
        else $error("delete count out of step with valid bits");

    a_skip_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(skip_valid_reg) == int'(skip_cnt_reg))
        else $error("skip count out of step with valid bits");

    // The tables change only at a commit.
    a_change_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        ((del_valid_reg != $past(del_valid_reg)) || (skip_valid_reg != $past(skip_valid_reg)))
        |-> $past(ctrl.commit))
        else $error("table changed outside a commit");

endmodule

>>> rtl/core/dual_toggle_set_compare.sv
// Each accepted command item is scanned slot by slot and then committed to the output register;
// a new item is accepted only after the previous one has committed. The slot scan visits
// one slot of the chosen table per cycle and then commits the update.
// A compare checks one delete-set slot per cycle against all skip-set slots at once.
// A finished result waits in the output register while the next item is scanned.
// Reset (rst_n, asynchronous) empties both tables and zeroes both counts at once.
module dual_toggle_set_compare
    import dts_pkg::*;
#(
    parameter int unsigned ENTRIES = 16
) (
    input  logic   clk,
    input  logic   rst_n,
    dts_cmd_if.sink   req,
    dts_res_if.source rsp
);

    localparam int unsigned IDX_W = $clog2(ENTRIES);

    dts_ctrl_t        ctrl;
    logic [IDX_W-1:0] idx;

    // Sequencing of each item.
    dts_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .ctrl      (ctrl),
        .idx       (idx)
    );

    // Tables, match logic and result register.
    dts_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .idx          (idx),
        .in_cmd       (req.cmd),
        .in_channel   (req.channel),
        .in_frequency (req.frequency),
        .status       (rsp.status),
        .found        (rsp.found),
        .sets_equal   (rsp.sets_equal),
        .delete_count (rsp.delete_count),
        .skip_count   (rsp.skip_count)
    );

endmodule

>>> bench/tb_dual_toggle_set_compare.sv
// Testbench for dual_toggle_set_compare: random handshakes checked against a shadow of both pair sets.
module tb_dual_toggle_set_compare;
    import dts_pkg::*;

    localparam int unsigned SLOTS          = 16;
    localparam int unsigned POOL           = 24;
    localparam int unsigned FLOOD          = 18;
    localparam int unsigned ITEMS_TOTAL    = 1350;
    localparam int unsigned MAX_WAIT       = 9;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned PRINT_LIMIT    = 100;

    // Set indexes of the shadow tables.
    localparam int DEL_SET  = 0;
    localparam int SKIP_SET = 1;

    // Command codes the block treats as no-ops.
    localparam logic [CMD_W-1:0] CMD_UNDEF_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNDEF_LAST  = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [CHAN_W-1:0] channel;
        logic [FREQ_W-1:0] frequency;
    } pair_cmd_t;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic              found;
        logic              sets_equal;
        logic [CNT_W-1:0]  delete_count;
        logic [CNT_W-1:0]  skip_count;
    } set_result_t;

    logic clk;
    logic rst_n;

    dts_cmd_if req_if ();
    dts_res_if rsp_if ();

    dual_toggle_set_compare #(
        .ENTRIES (SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow copy of both pair tables and their counts.
    logic              slot_valid [2][SLOTS];
    logic [CHAN_W-1:0] slot_chan  [2][SLOTS];
    logic [FREQ_W-1:0] slot_freq  [2][SLOTS];
    int unsigned       pair_count [2];

    pair_cmd_t   pending_cmds[$];
    set_result_t expected_results[$];

    // Pairs that the random part keeps coming back to.
    logic [CHAN_W-1:0] pool_chan [POOL];
    logic [FREQ_W-1:0] pool_freq [POOL];

    int unsigned queued_total;
    int unsigned cmds_sent;
    int unsigned results_checked;
    int unsigned fail_count;
    int unsigned full_seen;
    int unsigned removed_seen;
    int unsigned equal_seen;
    int unsigned found_seen;
    int unsigned idle_cycles;

    pair_cmd_t   next_cmd;
    int unsigned send_wait;
    bit          send_calm;
    set_result_t want;
    int unsigned hold;
    int unsigned recv_wait;
    bit          recv_calm;

    always #5 clk = ~clk;

    // Slot that holds the pair in set s, or -1 when the pair is absent.
    function automatic int find_pair(int s, logic [CHAN_W-1:0] ch, logic [FREQ_W-1:0] fr);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_valid[s][i] && slot_chan[s][i] == ch && slot_freq[s][i] == fr)
                return i;
        end
        return -1;
    endfunction

    // Removes a present pair, otherwise fills the lowest free slot.
    function automatic logic [STAT_W-1:0] toggle_pair(int s, logic [CHAN_W-1:0] ch,
                                                      logic [FREQ_W-1:0] fr);
        int hit;
        hit = find_pair(s, ch, fr);
        if (hit >= 0)
        begin
            slot_valid[s][hit] = 1'b0;
            slot_chan[s][hit]  = '0;
            slot_freq[s][hit]  = '0;
            pair_count[s]--;
            return STAT_REMOVED;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!slot_valid[s][i])
            begin
                slot_valid[s][i] = 1'b1;
                slot_chan[s][i]  = ch;
                slot_freq[s][i]  = fr;
                pair_count[s]++;
                return STAT_ADDED;
            end
        end
        return STAT_FULL;
    endfunction

    // Equal counts and every delete-set pair also present in the skip set.
    function automatic logic sets_match();
        if (pair_count[DEL_SET] != pair_count[SKIP_SET])
            return 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_valid[DEL_SET][i] &&
                find_pair(SKIP_SET, slot_chan[DEL_SET][i], slot_freq[DEL_SET][i]) < 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Applies one command to the shadow tables and returns the result it must give.
    function automatic set_result_t predict_result(logic [CMD_W-1:0] cmd,
                                                   logic [CHAN_W-1:0] ch,
                                                   logic [FREQ_W-1:0] fr);
        set_result_t r;
        r.status     = STAT_QUERY;
        r.found      = 1'b0;
        r.sets_equal = 1'b0;
        case (cmd)
            CMD_TOGGLE_DEL:  r.status = toggle_pair(DEL_SET, ch, fr);
            CMD_TOGGLE_SKIP: r.status = toggle_pair(SKIP_SET, ch, fr);
            CMD_COMPARE:     r.sets_equal = sets_match();
            CMD_SEARCH_DEL:  r.found = (find_pair(DEL_SET, ch, fr) >= 0);
            CMD_SEARCH_SKIP: r.found = (find_pair(SKIP_SET, ch, fr) >= 0);
            default:         ;
        endcase
        // Counts are reported in their low bits only.
        r.delete_count = pair_count[DEL_SET][CNT_W-1:0];
        r.skip_count   = pair_count[SKIP_SET][CNT_W-1:0];
        return r;
    endfunction

    function automatic logic [CMD_W-1:0] toggle_cmd(int s);
        return (s == DEL_SET) ? CMD_TOGGLE_DEL : CMD_TOGGLE_SKIP;
    endfunction

    function automatic logic [CMD_W-1:0] search_cmd(int s);
        return (s == DEL_SET) ? CMD_SEARCH_DEL : CMD_SEARCH_SKIP;
    endfunction

    // Idle cycles for one item; none at all during a calm stretch.
    function automatic int unsigned draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic push_cmd(logic [CMD_W-1:0] cmd, logic [CHAN_W-1:0] ch,
                            logic [FREQ_W-1:0] fr);
        pair_cmd_t c;
        c.cmd       = cmd;
        c.channel   = ch;
        c.frequency = fr;
        pending_cmds.push_back(c);
        queued_total++;
    endtask

    // Printing stops after the first hundred mismatches to keep the log short.
    task automatic report_mismatch(string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("MISMATCH: %s", msg);
    endtask

    // Fills set s with fresh pairs until it overflows, then takes them out in reverse order.
    task automatic flood_set(int s);
        logic [CHAN_W-1:0] fc [FLOOD];
        logic [FREQ_W-1:0] ff [FLOOD];
        for (int i = 0; i < FLOOD; i++)
        begin
            fc[i] = CHAN_W'($urandom());
            ff[i] = FREQ_W'($urandom());
            push_cmd(toggle_cmd(s), fc[i], ff[i]);
        end
        push_cmd(CMD_COMPARE, '0, '0);
        push_cmd(search_cmd(s), fc[0], ff[0]);
        for (int i = FLOOD - 1; i >= 0; i--)
            push_cmd(toggle_cmd(s), fc[i], ff[i]);
    endtask

    // Driver: presents queued items and predicts each one as it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            send_wait    <= 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                expected_results.push_back(
                    predict_result(req_if.cmd, req_if.channel, req_if.frequency));
                cmds_sent++;
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (send_wait != 0)
                begin
                    req_if.valid <= 1'b0;
                    send_wait    <= send_wait - 1;
                end
                else if (pending_cmds.size() != 0)
                begin
                    next_cmd = pending_cmds.pop_front();
                    req_if.valid     <= 1'b1;
                    req_if.cmd       <= next_cmd.cmd;
                    req_if.channel   <= next_cmd.channel;
                    req_if.frequency <= next_cmd.frequency;
                    if ($urandom_range(0, 15) == 0)
                        send_calm = !send_calm;
                    send_wait <= draw_wait(send_calm);
                end
                else
                begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result item against the oldest prediction and stalls at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            recv_wait    <= 0;
        end
        else
        begin
            hold = recv_wait;
            if (rsp_if.valid && rsp_if.ready)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d arrived with no command pending",
                                              results_checked));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_if.status !== want.status)
                        report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                                  results_checked, rsp_if.status, want.status));
                    if (rsp_if.found !== want.found)
                        report_mismatch($sformatf("result %0d found %0b, expected %0b",
                                                  results_checked, rsp_if.found, want.found));
                    if (rsp_if.sets_equal !== want.sets_equal)
                        report_mismatch($sformatf("result %0d sets_equal %0b, expected %0b",
                                                  results_checked, rsp_if.sets_equal,
                                                  want.sets_equal));
                    if (rsp_if.delete_count !== want.delete_count)
                        report_mismatch($sformatf("result %0d delete_count %0d, expected %0d",
                                                  results_checked, rsp_if.delete_count,
                                                  want.delete_count));
                    if (rsp_if.skip_count !== want.skip_count)
                        report_mismatch($sformatf("result %0d skip_count %0d, expected %0d",
                                                  results_checked, rsp_if.skip_count,
                                                  want.skip_count));
                    if (want.status == STAT_FULL)
                        full_seen++;
                    if (want.status == STAT_REMOVED)
                        removed_seen++;
                    if (want.sets_equal)
                        equal_seen++;
                    if (want.found)
                        found_seen++;
                end
                if ($urandom_range(0, 15) == 0)
                    recv_calm = !recv_calm;
                hold = draw_wait(recv_calm);
            end
            if (hold != 0)
            begin
                rsp_if.ready <= 1'b0;
                recv_wait    <= hold - 1;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                recv_wait    <= 0;
            end
        end
    end

    // Watchdog: ends the run when no item moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int pick;
        int p;
        int s;

        clk              = 1'b0;
        rst_n            = 1'b0;
        req_if.valid     = 1'b0;
        req_if.cmd       = CMD_COMPARE;
        req_if.channel   = '0;
        req_if.frequency = '0;
        rsp_if.ready     = 1'b0;
        idle_cycles      = 0;
        for (int k = 0; k < 2; k++)
        begin
            pair_count[k] = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_valid[k][i] = 1'b0;
                slot_chan[k][i]  = '0;
                slot_freq[k][i]  = '0;
            end
        end

        // Corner pairs first, including one that differs from another only in frequency.
        pool_chan[0] = '0;  pool_freq[0] = '0;
        pool_chan[1] = '1;  pool_freq[1] = '1;
        pool_chan[2] = '1;  pool_freq[2] = '0;
        pool_chan[3] = '0;  pool_freq[3] = '1;
        pool_chan[4] = '1;  pool_freq[4] = {{(FREQ_W - 1){1'b1}}, 1'b0};
        for (int i = 5; i < POOL; i++)
        begin
            pool_chan[i] = CHAN_W'($urandom());
            pool_freq[i] = FREQ_W'($urandom());
        end

        // Directed opening: empty compare, adds, removals, lookups and unused codes.
        push_cmd(CMD_COMPARE, '0, '0);
        push_cmd(CMD_SEARCH_DEL, pool_chan[0], pool_freq[0]);
        push_cmd(CMD_TOGGLE_DEL, pool_chan[0], pool_freq[0]);
        push_cmd(CMD_TOGGLE_DEL, pool_chan[1], pool_freq[1]);
        push_cmd(CMD_SEARCH_DEL, pool_chan[1], pool_freq[1]);
        push_cmd(CMD_SEARCH_DEL, pool_chan[4], pool_freq[4]);
        push_cmd(CMD_COMPARE, '0, '0);
        push_cmd(CMD_TOGGLE_SKIP, pool_chan[1], pool_freq[1]);
        push_cmd(CMD_TOGGLE_SKIP, pool_chan[2], pool_freq[2]);
        push_cmd(CMD_COMPARE, '0, '0);
        push_cmd(CMD_TOGGLE_SKIP, pool_chan[2], pool_freq[2]);
        push_cmd(CMD_TOGGLE_SKIP, pool_chan[0], pool_freq[0]);
        push_cmd(CMD_COMPARE, '1, '1);
        push_cmd(CMD_SEARCH_SKIP, pool_chan[0], pool_freq[0]);
        push_cmd(CMD_SEARCH_SKIP, pool_chan[3], pool_freq[3]);
        push_cmd(CMD_TOGGLE_DEL, pool_chan[0], pool_freq[0]);
        push_cmd(CMD_TOGGLE_DEL, pool_chan[3], pool_freq[3]);
        push_cmd(CMD_UNDEF_FIRST, pool_chan[3], pool_freq[3]);
        push_cmd(CMD_UNDEF_FIRST + 3'd1, '1, '1);
        push_cmd(CMD_UNDEF_LAST, '0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Hold off until the directed part has fully drained.
        while (pending_cmds.size() != 0 || req_if.valid || expected_results.size() != 0)
            @(negedge clk);

        // The delete set surely overflows here; after that the mix is random.
        flood_set(DEL_SET);
        while (queued_total < ITEMS_TOTAL)
        begin
            pick = $urandom_range(0, 99);
            p    = $urandom_range(0, POOL - 1);
            s    = $urandom_range(0, 1);
            if (pick < 30)
            begin
                // Same pair into both sets, so that compares often come out equal.
                push_cmd(toggle_cmd(s), pool_chan[p], pool_freq[p]);
                push_cmd(toggle_cmd(1 - s), pool_chan[p], pool_freq[p]);
                if ($urandom_range(0, 1) == 1)
                    push_cmd(CMD_COMPARE, CHAN_W'($urandom()), FREQ_W'($urandom()));
            end
            else if (pick < 48)
                push_cmd(toggle_cmd(s), pool_chan[p], pool_freq[p]);
            else if (pick < 62)
                push_cmd(search_cmd(s), pool_chan[p], pool_freq[p]);
            else if (pick < 72)
                push_cmd(CMD_COMPARE, CHAN_W'($urandom()), FREQ_W'($urandom()));
            else if (pick < 74)
                flood_set(s);
            else if (pick < 76)
            begin
                for (int i = 0; i < POOL; i++)
                    push_cmd(toggle_cmd(s), pool_chan[i], pool_freq[i]);
            end
            else if (pick < 88)
                push_cmd(CMD_W'($urandom_range(0, (1 << CMD_W) - 1)), CHAN_W'($urandom()),
                         FREQ_W'($urandom()));
            else if (pick < 92)
                push_cmd(CMD_W'($urandom_range(CMD_UNDEF_FIRST, CMD_UNDEF_LAST)),
                         CHAN_W'($urandom()), FREQ_W'($urandom()));
            else
            begin
                // One-sided toggle followed by a compare.
                push_cmd(toggle_cmd(s), pool_chan[p], pool_freq[p]);
                push_cmd(CMD_COMPARE, '0, '0);
            end
        end

        while (pending_cmds.size() != 0 || req_if.valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (SLOTS + 8) @(negedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        $display("Sent %0d commands and checked %0d results.", cmds_sent, results_checked);
        $display("Seen: %0d removals, %0d table-full rejects, %0d equal compares, %0d hits.",
                 removed_seen, full_seen, equal_seen, found_seen);
        if (fail_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
